/* sv/rfbs_pkg.sv */
// ----------------------------------------------------------------------------
// rfbs_pkg
// Shared types and constants of the bidisperse shallow-flow Rusanov flux core.
// ----------------------------------------------------------------------------
package rfbs_pkg;

	localparam int WORD_BITS_DEF     = 32;
	localparam int FRACTION_BITS_DEF = 24;

	localparam int CFG_DATA_BITS  = 31;
	localparam int CFG_INDEX_BITS = 2;

	localparam logic [30:0] GRAVITY_SCALE_RST      = 31'd16777216;
	localparam logic [24:0] COS_SLOPE_RST          = 25'd16777216;
	localparam logic [30:0] MIN_HEIGHT_RST         = 31'd168;
	localparam logic [24:0] SEGREGATION_FACTOR_RST = 25'd8388608;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_GRAVITY_SCALE      = 2'd0,
		REG_COS_SLOPE          = 2'd1,
		REG_MIN_HEIGHT         = 2'd2,
		REG_SEGREGATION_FACTOR = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [30:0] gravity_scale;
		logic [24:0] cos_slope;
		logic [30:0] min_height;
		logic [24:0] segregation_factor;
	} cfg_t;

endpackage

/* sv/rfbs_div.sv */
// ----------------------------------------------------------------------------
// rfbs_div
// Pipelined restoring divider: sat(num * 2^F / den), truncated toward zero,
// one quotient bit per stage. den is taken as positive.
// ----------------------------------------------------------------------------
module rfbs_div #(
	parameter int WORD_BITS     = rfbs_pkg::WORD_BITS_DEF,
	parameter int FRACTION_BITS = rfbs_pkg::FRACTION_BITS_DEF,
	parameter int TAG_W         = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic signed [WORD_BITS-1:0] num,
	input  logic signed [WORD_BITS-1:0] den,
	input  logic [TAG_W-1:0]            tag_in,
	output logic                        out_valid,
	output logic signed [WORD_BITS-1:0] quo,
	output logic [TAG_W-1:0]            tag_out
);

	localparam int QB = WORD_BITS + 1;
	localparam int AW = WORD_BITS + FRACTION_BITS;

	logic [WORD_BITS-1:0] mag;
	logic [WORD_BITS-1:0] den_u;
	logic [AW-1:0]        abig;
	logic                 ovf0;

	assign mag   = num[WORD_BITS-1] ? (~num + 1'b1) : num;
	assign den_u = den;
	assign abig  = {mag, {FRACTION_BITS{1'b0}}};
	assign ovf0  = {{(WORD_BITS - FRACTION_BITS + 1){1'b0}}, abig[AW-1:QB]} >= den_u;

	logic [WORD_BITS-1:0] rem_s  [QB+1];
	logic [QB-1:0]        quo_s  [QB+1];
	logic [QB-1:0]        abit_s [QB+1];
	logic [WORD_BITS-1:0] den_s  [QB+1];
	logic                 neg_s  [QB+1];
	logic                 ovf_s  [QB+1];
	logic                 vld_s  [QB+1];
	logic [TAG_W-1:0]     tag_s  [QB+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= {{(WORD_BITS - FRACTION_BITS + 1){1'b0}}, abig[AW-1:QB]};
			quo_s[0]  <= '0;
			abit_s[0] <= abig[QB-1:0];
			den_s[0]  <= den_u;
			neg_s[0]  <= num[WORD_BITS-1];
			ovf_s[0]  <= ovf0;
			tag_s[0]  <= tag_in;
		end
	end

	for (genvar k = 1; k <= QB; k++) begin : g_stage
		logic [WORD_BITS:0] trial;
		logic               ge;

		assign trial = {rem_s[k-1], abit_s[k-1][QB-1]};
		assign ge    = trial >= {1'b0, den_s[k-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? WORD_BITS'(trial - {1'b0, den_s[k-1]})
				                : trial[WORD_BITS-1:0];
				quo_s[k]  <= {quo_s[k-1][QB-2:0], ge};
				abit_s[k] <= {abit_s[k-1][QB-2:0], 1'b0};
				den_s[k]  <= den_s[k-1];
				neg_s[k]  <= neg_s[k-1];
				ovf_s[k]  <= ovf_s[k-1];
				tag_s[k]  <= tag_s[k-1];
			end
		end
	end

	logic [QB-1:0]        q_fin;
	logic signed [WORD_BITS-1:0] res;

	assign q_fin = quo_s[QB];

	always_comb begin
		if (neg_s[QB]) begin
			if (ovf_s[QB] || (q_fin > {2'b01, {(WORD_BITS - 1){1'b0}}})) begin
				res = {1'b1, {(WORD_BITS - 1){1'b0}}};
			end else begin
				res = ~q_fin[WORD_BITS-1:0] + 1'b1;
			end
		end else begin
			if (ovf_s[QB] || (q_fin[QB-1:WORD_BITS-1] != '0)) begin
				res = {1'b0, {(WORD_BITS - 1){1'b1}}};
			end else begin
				res = q_fin[WORD_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= vld_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo     <= res;
			tag_out <= tag_s[QB];
		end
	end

endmodule

/* sv/rfbs_sqrt.sv */
// ----------------------------------------------------------------------------
// rfbs_sqrt
// Pipelined digit-by-digit square root: floor(sqrt(e * 2^F)) for e >= 0,
// one root bit per stage.
// ----------------------------------------------------------------------------
module rfbs_sqrt #(
	parameter int WORD_BITS     = rfbs_pkg::WORD_BITS_DEF,
	parameter int FRACTION_BITS = rfbs_pkg::FRACTION_BITS_DEF,
	parameter int TAG_W         = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic signed [WORD_BITS-1:0] val,
	input  logic [TAG_W-1:0]            tag_in,
	output logic                        out_valid,
	output logic [WORD_BITS-1:0]        root,
	output logic [TAG_W-1:0]            tag_out
);

	localparam int RB = (WORD_BITS + FRACTION_BITS + 1) / 2;
	localparam int XB = 2 * RB;

	logic [XB-1:0] x0;

	assign x0 = XB'(val[WORD_BITS-2:0]) << FRACTION_BITS;

	logic [RB+1:0]    rem_s  [RB+1];
	logic [RB-1:0]    root_s [RB+1];
	logic [XB-1:0]    x_s    [RB+1];
	logic             vld_s  [RB+1];
	logic [TAG_W-1:0] tag_s  [RB+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= '0;
			root_s[0] <= '0;
			x_s[0]    <= x0;
			tag_s[0]  <= tag_in;
		end
	end

	for (genvar k = 1; k <= RB; k++) begin : g_stage
		logic [RB+1:0] remsh;
		logic [RB+1:0] trial;
		logic          ge;

		assign remsh = {rem_s[k-1][RB-1:0], x_s[k-1][XB-1:XB-2]};
		assign trial = {root_s[k-1], 2'b01};
		assign ge    = remsh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? (remsh - trial) : remsh;
				root_s[k] <= {root_s[k-1][RB-2:0], ge};
				x_s[k]    <= {x_s[k-1][XB-3:0], 2'b00};
				tag_s[k]  <= tag_s[k-1];
			end
		end
	end

	assign out_valid = vld_s[RB];
	assign root      = {{(WORD_BITS - RB){1'b0}}, root_s[RB]};
	assign tag_out   = tag_s[RB];

endmodule

/* sv/rfbs_side.sv */
// ----------------------------------------------------------------------------
// rfbs_side
// One side of a face: velocity, physical flux and local wave speed of a
// state (height, momentum, small-particle height).
// ----------------------------------------------------------------------------
module rfbs_side #(
	parameter int WORD_BITS     = rfbs_pkg::WORD_BITS_DEF,
	parameter int FRACTION_BITS = rfbs_pkg::FRACTION_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  rfbs_pkg::cfg_t              cfg,
	input  logic                        in_valid,
	input  logic signed [WORD_BITS-1:0] h,
	input  logic signed [WORD_BITS-1:0] m,
	input  logic signed [WORD_BITS-1:0] s,
	output logic                        out_valid,
	output logic signed [WORD_BITS-1:0] q_h,
	output logic signed [WORD_BITS-1:0] q_m,
	output logic signed [WORD_BITS-1:0] q_s,
	output logic signed [WORD_BITS-1:0] f_mom,
	output logic signed [WORD_BITS-1:0] f_small,
	output logic signed [WORD_BITS-1:0] speed
);

	localparam int PW = 2 * WORD_BITS + 2;

	typedef logic signed [WORD_BITS-1:0] word_t;
	typedef logic signed [PW-1:0]        wide_t;

	localparam wide_t WMAX = (wide_t'(1) <<< (WORD_BITS - 1)) - wide_t'(1);
	localparam wide_t WMIN = -WMAX - wide_t'(1);
	localparam wide_t ONE  = wide_t'(1) <<< FRACTION_BITS;

	function automatic word_t sat(input wide_t x);
		word_t r;
		if (x > WMAX) begin
			r = WMAX[WORD_BITS-1:0];
		end else if (x < WMIN) begin
			r = WMIN[WORD_BITS-1:0];
		end else begin
			r = x[WORD_BITS-1:0];
		end
		return r;
	endfunction

	function automatic word_t fx_mul(input word_t a, input word_t b);
		wide_t p;
		p = wide_t'(a) * wide_t'(b);
		return sat(p >>> FRACTION_BITS);
	endfunction

	typedef struct packed {
		logic  hv;
		word_t h;
		word_t m;
		word_t s;
	} utag_t;

	typedef struct packed {
		word_t p1;
		word_t e;
	} rtag_t;

	typedef struct packed {
		word_t h;
		word_t m;
		word_t s;
		word_t f1;
		word_t f2;
		word_t au;
	} qtag_t;

	// register values clamped to the word range
	word_t eps, cs, hmin, alpha, oma;
	word_t k_q;

	assign eps   = sat(wide_t'(cfg.gravity_scale));
	assign cs    = sat(wide_t'(cfg.cos_slope));
	assign hmin  = sat(wide_t'(cfg.min_height));
	assign alpha = sat(wide_t'(cfg.segregation_factor));
	assign oma   = sat(ONE - wide_t'(alpha));

	// eps*cos/2, follows the registers
	always_ff @(posedge clk) begin
		k_q <= sat((wide_t'(eps) * wide_t'(cs)) >>> (FRACTION_BITS + 1));
	end

	// input stage
	logic  valid_s1;
	word_t h_s1, m_s1, s_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			h_s1 <= h;
			m_s1 <= m;
			s_s1 <= s;
		end
	end

	utag_t utag_in, utag_out;
	rtag_t rtag_in, rtag_out;
	logic  vu, vr;
	word_t u_raw, r_raw;

	assign utag_in.hv = h_s1 > hmin;
	assign utag_in.h  = h_s1;
	assign utag_in.m  = m_s1;
	assign utag_in.s  = s_s1;
	assign rtag_in.p1 = fx_mul(k_q, h_s1);
	assign rtag_in.e  = fx_mul(eps, h_s1[WORD_BITS-1] ? word_t'(0) : h_s1);

	rfbs_div #(
		.WORD_BITS(WORD_BITS),
		.FRACTION_BITS(FRACTION_BITS),
		.TAG_W($bits(utag_t))
	) u_div_vel (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(valid_s1),
		.num(m_s1),
		.den(h_s1),
		.tag_in(utag_in),
		.out_valid(vu),
		.quo(u_raw),
		.tag_out(utag_out)
	);

	rfbs_div #(
		.WORD_BITS(WORD_BITS),
		.FRACTION_BITS(FRACTION_BITS),
		.TAG_W($bits(rtag_t))
	) u_div_ratio (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(valid_s1),
		.num(s_s1),
		.den(h_s1),
		.tag_in(rtag_in),
		.out_valid(vr),
		.quo(r_raw),
		.tag_out(rtag_out)
	);

	// velocity is zero at or below the minimum height
	word_t u_c;
	assign u_c = utag_out.hv ? u_raw : word_t'(0);

	logic  valid_s2, hv_s2;
	word_t h_s2, m_s2, s_s2, u_s2, mu_s2, su_s2, p_s2, r_s2, oms_s2, au_s2, e_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= vu & vr;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hv_s2  <= utag_out.hv;
			h_s2   <= utag_out.h;
			m_s2   <= utag_out.m;
			s_s2   <= utag_out.s;
			u_s2   <= u_c;
			mu_s2  <= fx_mul(utag_out.m, u_c);
			su_s2  <= fx_mul(utag_out.s, u_c);
			p_s2   <= fx_mul(rtag_out.p1, utag_out.h);
			r_s2   <= sat(ONE - wide_t'(r_raw));
			oms_s2 <= fx_mul(oma, utag_out.s);
			au_s2  <= sat(u_c[WORD_BITS-1] ? -wide_t'(u_c) : wide_t'(u_c));
			e_s2   <= rtag_out.e;
		end
	end

	logic  valid_s3, hv_s3;
	word_t h_s3, m_s3, s_s3, f1_s3, su_s3, c1_s3, r_s3, au_s3, e_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hv_s3 <= hv_s2;
			h_s3  <= h_s2;
			m_s3  <= m_s2;
			s_s3  <= s_s2;
			f1_s3 <= sat(wide_t'(mu_s2) + wide_t'(p_s2));
			su_s3 <= su_s2;
			c1_s3 <= fx_mul(oms_s2, u_s2);
			r_s3  <= r_s2;
			au_s3 <= au_s2;
			e_s3  <= e_s2;
		end
	end

	logic  valid_s4;
	word_t c2;
	qtag_t qtag_s4;
	word_t e_s4;

	assign c2 = fx_mul(c1_s3, r_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	// segregation correction only above the minimum height
	always_ff @(posedge clk) begin
		if (en) begin
			qtag_s4.h  <= h_s3;
			qtag_s4.m  <= m_s3;
			qtag_s4.s  <= s_s3;
			qtag_s4.f1 <= f1_s3;
			qtag_s4.f2 <= hv_s3 ? sat(wide_t'(su_s3) - wide_t'(c2)) : su_s3;
			qtag_s4.au <= au_s3;
			e_s4       <= e_s3;
		end
	end

	logic                 vq;
	logic [WORD_BITS-1:0] root;
	qtag_t                qtag_out;

	rfbs_sqrt #(
		.WORD_BITS(WORD_BITS),
		.FRACTION_BITS(FRACTION_BITS),
		.TAG_W($bits(qtag_t))
	) u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(valid_s4),
		.val(e_s4),
		.tag_in(qtag_s4),
		.out_valid(vq),
		.root(root),
		.tag_out(qtag_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= vq;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_h     <= qtag_out.h;
			q_m     <= qtag_out.m;
			q_s     <= qtag_out.s;
			f_mom   <= qtag_out.f1;
			f_small <= qtag_out.f2;
			speed   <= sat(wide_t'(qtag_out.au) + wide_t'({1'b0, root}));
		end
	end

endmodule

/* sv/rusanov_flux_bidisperse_shallow_core.sv */
// ----------------------------------------------------------------------------
// rusanov_flux_bidisperse_shallow_core
// Local Lax-Friedrichs face flux for the bidisperse shallow granular flow
// equations, saturated signed fixed point.
// ----------------------------------------------------------------------------
// throughput: one word per cycle, every stage advances together unless the
//   output word is held by out_stall
// latency is set by the bit-per-stage dividers and the bit-per-stage square root
// reset clears all valid bits and loads the register defaults
module rusanov_flux_bidisperse_shallow_core #(
	parameter int WORD_BITS     = rfbs_pkg::WORD_BITS_DEF,
	parameter int FRACTION_BITS = rfbs_pkg::FRACTION_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [rfbs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [rfbs_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [WORD_BITS-1:0]         height_left,
	input  logic signed [WORD_BITS-1:0]         momentum_left,
	input  logic signed [WORD_BITS-1:0]         small_left,
	input  logic signed [WORD_BITS-1:0]         height_right,
	input  logic signed [WORD_BITS-1:0]         momentum_right,
	input  logic signed [WORD_BITS-1:0]         small_right,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [WORD_BITS-1:0]         flux_mass,
	output logic signed [WORD_BITS-1:0]         flux_momentum,
	output logic signed [WORD_BITS-1:0]         flux_small
);

	localparam int PW = 2 * WORD_BITS + 2;

	typedef logic signed [WORD_BITS-1:0] word_t;
	typedef logic signed [WORD_BITS:0]   sum_t;
	typedef logic signed [PW-1:0]        wide_t;

	localparam wide_t WMAX = (wide_t'(1) <<< (WORD_BITS - 1)) - wide_t'(1);
	localparam wide_t WMIN = -WMAX - wide_t'(1);

	function automatic word_t sat(input wide_t x);
		word_t r;
		if (x > WMAX) begin
			r = WMAX[WORD_BITS-1:0];
		end else if (x < WMIN) begin
			r = WMIN[WORD_BITS-1:0];
		end else begin
			r = x[WORD_BITS-1:0];
		end
		return r;
	endfunction

	// configuration registers
	rfbs_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gravity_scale      <= rfbs_pkg::GRAVITY_SCALE_RST;
			cfg_q.cos_slope          <= rfbs_pkg::COS_SLOPE_RST;
			cfg_q.min_height         <= rfbs_pkg::MIN_HEIGHT_RST;
			cfg_q.segregation_factor <= rfbs_pkg::SEGREGATION_FACTOR_RST;
		end else if (cfg_we) begin
			unique case (rfbs_pkg::cfg_reg_t'(cfg_index))
				rfbs_pkg::REG_GRAVITY_SCALE: begin
					cfg_q.gravity_scale <= cfg_data[30:0];
				end
				rfbs_pkg::REG_COS_SLOPE: begin
					cfg_q.cos_slope <= cfg_data[24:0];
				end
				rfbs_pkg::REG_MIN_HEIGHT: begin
					cfg_q.min_height <= cfg_data[30:0];
				end
				rfbs_pkg::REG_SEGREGATION_FACTOR: begin
					cfg_q.segregation_factor <= cfg_data[24:0];
				end
			endcase
		end
	end

	// whole pipeline holds while the output word waits
	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	logic  vl, vr;
	word_t hl, ml, sl, fml, fsl, spl;
	word_t hr, mr, sr, fmr, fsr, spr;

	rfbs_side #(
		.WORD_BITS(WORD_BITS),
		.FRACTION_BITS(FRACTION_BITS)
	) u_side_left (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.cfg(cfg_q),
		.in_valid(in_valid),
		.h(height_left),
		.m(momentum_left),
		.s(small_left),
		.out_valid(vl),
		.q_h(hl),
		.q_m(ml),
		.q_s(sl),
		.f_mom(fml),
		.f_small(fsl),
		.speed(spl)
	);

	rfbs_side #(
		.WORD_BITS(WORD_BITS),
		.FRACTION_BITS(FRACTION_BITS)
	) u_side_right (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.cfg(cfg_q),
		.in_valid(in_valid),
		.h(height_right),
		.m(momentum_right),
		.s(small_right),
		.out_valid(vr),
		.q_h(hr),
		.q_m(mr),
		.q_s(sr),
		.f_mom(fmr),
		.f_small(fsr),
		.speed(spr)
	);

	// stage 1: wave speed, jumps and flux sums
	logic  vld_s1;
	word_t a_s1;
	sum_t  d_s1 [3];
	sum_t  fs_s1 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vl & vr;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1     <= (spl > spr) ? spl : spr;
			d_s1[0]  <= sum_t'(hr) - sum_t'(hl);
			d_s1[1]  <= sum_t'(mr) - sum_t'(ml);
			d_s1[2]  <= sum_t'(sr) - sum_t'(sl);
			fs_s1[0] <= sum_t'(ml) + sum_t'(mr);
			fs_s1[1] <= sum_t'(fml) + sum_t'(fmr);
			fs_s1[2] <= sum_t'(fsl) + sum_t'(fsr);
		end
	end

	// stage 2: dissipation term subtracted from the flux sum
	logic  vld_s2;
	wide_t t_s2 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_comp
		always_ff @(posedge clk) begin
			if (en) begin
				t_s2[i] <= wide_t'(fs_s1[i])
				           - ((wide_t'(a_s1) * wide_t'(d_s1[i])) >>> FRACTION_BITS);
			end
		end
	end

	// stage 3: halve and saturate into the output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flux_mass     <= sat(t_s2[0] >>> 1);
			flux_momentum <= sat(t_s2[1] >>> 1);
			flux_small    <= sat(t_s2[2] >>> 1);
		end
	end

	// input is held back only by a waiting output word
	assert property (@(posedge clk) disable iff (!arst_n) in_stall |-> out_valid)
		else $error("input stalled with no output word waiting");

	// a held pipeline keeps its stage contents
	assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> ($stable(vld_s1) && $stable(vld_s2) && $stable(a_s1)))
		else $error("combine stages moved while held");

	// wave speed is never negative
	assert property (@(posedge clk) disable iff (!arst_n) vld_s1 |-> !a_s1[WORD_BITS-1])
		else $error("negative wave speed");

	// both sides stay in lock step
	assert property (@(posedge clk) disable iff (!arst_n) vl == vr)
		else $error("left and right side pipelines out of step");

endmodule
